[sv/lr_pkg.sv]
// ============================================================================
// lr_pkg
// Shared widths, request codes and record types of the line rasterizer.
// ============================================================================
package lr_pkg;

    localparam int COORD_BITS  = 9;
    localparam int COLOR_BITS  = 16;
    localparam int ERR_BITS    = COORD_BITS + 2;
    localparam int S_DATA_BITS = ((4 * COORD_BITS + COLOR_BITS + 7) / 8) * 8;
    localparam int M_DATA_BITS = ((2 * COORD_BITS + COLOR_BITS + 7) / 8) * 8;

    typedef enum logic {
        REQ_LOAD  = 1'b0,
        REQ_PIXEL = 1'b1
    } t_req;

    typedef logic [COORD_BITS-1:0] t_coord;
    typedef logic [COLOR_BITS-1:0] t_color;

    typedef struct packed {
        logic                       active;
        t_coord                     cur_x;
        t_coord                     cur_y;
        logic signed [ERR_BITS-1:0] err_term;
        t_coord                     abs_dx;
        t_coord                     abs_dy;
        logic                       x_negative;
        logic                       y_negative;
        logic                       x_major;
        t_coord                     steps_left;
        t_color                     held_color;
    } t_line_state;

    typedef struct packed {
        t_coord x;
        t_coord y;
        t_color color;
        logic   last;
    } t_pixel;

endpackage

[sv/lr_core.sv]
// ============================================================================
// lr_core
// Next-state and pixel logic for one request: line setup or one line step.
// ============================================================================
module lr_core
    import lr_pkg::*;
(
    input  t_line_state i_state,
    input  t_req        i_req,
    input  t_coord      i_start_x,
    input  t_coord      i_start_y,
    input  t_coord      i_end_x,
    input  t_coord      i_end_y,
    input  t_color      i_line_color,
    output t_line_state o_state,
    output logic        o_emit,
    output t_pixel      o_pixel
);

    logic                       x_neg;
    logic                       y_neg;
    t_coord                     dx;
    t_coord                     dy;
    logic                       major_x;
    t_coord                     steps;
    t_coord                     major_d;
    t_coord                     minor_d;
    logic                       err_le0;
    logic signed [ERR_BITS-1:0] err_add;
    logic signed [ERR_BITS-1:0] err_sub;

    always_comb begin
        x_neg   = i_end_x < i_start_x;
        y_neg   = i_end_y < i_start_y;
        dx      = x_neg ? (i_start_x - i_end_x) : (i_end_x - i_start_x);
        dy      = y_neg ? (i_start_y - i_end_y) : (i_end_y - i_start_y);
        major_x = dx > dy;
        steps   = major_x ? dx : dy;

        major_d = i_state.x_major ? i_state.abs_dx : i_state.abs_dy;
        minor_d = i_state.x_major ? i_state.abs_dy : i_state.abs_dx;
        err_le0 = i_state.err_term <= $signed({ERR_BITS{1'b0}});
        err_add = err_le0 ? $signed({2'b00, major_d}) : $signed({ERR_BITS{1'b0}});
        err_sub = $signed({2'b00, minor_d});

        o_state       = i_state;
        o_emit        = 1'b0;
        o_pixel.x     = i_state.cur_x;
        o_pixel.y     = i_state.cur_y;
        o_pixel.color = i_state.held_color;
        o_pixel.last  = i_state.steps_left == '0;

        unique case (i_req)
            REQ_LOAD: begin
                o_state.active     = 1'b1;
                o_state.cur_x      = i_start_x;
                o_state.cur_y      = i_start_y;
                o_state.abs_dx     = dx;
                o_state.abs_dy     = dy;
                o_state.x_negative = x_neg;
                o_state.y_negative = y_neg;
                o_state.x_major    = major_x;
                o_state.steps_left = steps;
                o_state.err_term   = $signed({2'b00, 1'b0, steps[COORD_BITS-1:1]});
                o_state.held_color = i_line_color;
            end
            REQ_PIXEL: begin
                if (i_state.active) begin
                    o_emit = 1'b1;
                    if (i_state.steps_left == '0) begin
                        o_state.active = 1'b0;
                    end else begin
                        o_state.err_term   = i_state.err_term + err_add - err_sub;
                        o_state.steps_left = i_state.steps_left - 1'b1;
                        if (i_state.x_major || err_le0) begin
                            o_state.cur_x = i_state.x_negative ? i_state.cur_x - 1'b1
                                                               : i_state.cur_x + 1'b1;
                        end
                        if (!i_state.x_major || err_le0) begin
                            o_state.cur_y = i_state.y_negative ? i_state.cur_y - 1'b1
                                                               : i_state.cur_y + 1'b1;
                        end
                    end
                end
            end
            default: begin
                o_state = i_state;
            end
        endcase
    end

endmodule

[sv/line_rasterizer.sv]
// ============================================================================
// line_rasterizer
// Integer line rasterizer: a load word sets up a line, each pixel word
// returns the next pixel of that line with its color.
// ============================================================================
//
//  channel   dir  data                                       side band
//  s_axis    in   start_x, start_y, end_x, end_y, line_color tuser = req_type
//  m_axis    out  pixel_x, pixel_y, pixel_color              tlast = last_pixel
//
//  A word is taken in every cycle in which the output register is empty or
//  being drained, so lines stream at one pixel per clock.
//  A pixel shows on m_axis in the cycle after its request word is accepted.
//  Load words and pixel requests without an active line give no output.
//  Reset is synchronous and active low; it leaves no line loaded.
//  A stall on m_axis holds the output word and stops s_axis the same cycle.
//
module line_rasterizer
    import lr_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // start_x, start_y, end_x, end_y, line_color, zero fill
    input  logic [S_DATA_BITS-1:0] s_axis_tdata,
    // req_type
    input  logic [0:0]             s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // pixel_x, pixel_y, pixel_color, zero fill
    output logic [M_DATA_BITS-1:0] m_axis_tdata,
    output logic                   m_axis_tlast
);

    t_line_state r_st;
    t_line_state n_st;
    logic        r_m_valid;
    t_pixel      r_m_pix;
    t_pixel      n_m_pix;
    logic        emit;
    logic        s_fire;

    assign s_axis_tready = !r_m_valid || m_axis_tready;
    assign s_fire        = s_axis_tvalid && s_axis_tready;

    lr_core u_core (
        .i_state      (r_st),
        .i_req        (t_req'(s_axis_tuser[0])),
        .i_start_x    (s_axis_tdata[COORD_BITS-1:0]),
        .i_start_y    (s_axis_tdata[2*COORD_BITS-1:COORD_BITS]),
        .i_end_x      (s_axis_tdata[3*COORD_BITS-1:2*COORD_BITS]),
        .i_end_y      (s_axis_tdata[4*COORD_BITS-1:3*COORD_BITS]),
        .i_line_color (s_axis_tdata[4*COORD_BITS+COLOR_BITS-1:4*COORD_BITS]),
        .o_state      (n_st),
        .o_emit       (emit),
        .o_pixel      (n_m_pix)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st      <= '0;
            r_m_valid <= 1'b0;
        end else begin
            if (s_fire) begin
                r_st <= n_st;
            end
            if (s_fire && emit) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_fire && emit) begin
            r_m_pix <= n_m_pix;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = M_DATA_BITS'({r_m_pix.color, r_m_pix.y, r_m_pix.x});
    assign m_axis_tlast  = r_m_pix.last;

    a_load_activates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_fire && s_axis_tuser[0] == REQ_LOAD) |=> r_st.active)
        else $error("line not active after a load word");

    a_idle_no_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_fire && s_axis_tuser[0] == REQ_PIXEL && !r_st.active && !r_m_valid)
        |=> !m_axis_tvalid)
        else $error("pixel produced without an active line");

    a_last_ends_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_fire && s_axis_tuser[0] == REQ_PIXEL && r_st.active && r_st.steps_left == '0)
        |=> (!r_st.active && m_axis_tvalid && m_axis_tlast))
        else $error("final pixel not flagged or line still active");

endmodule

[bench/line_rasterizer_tb.sv]
`timescale 1ns / 1ps
// ============================================================================
// line_rasterizer_tb
// Self-checking bench for the line rasterizer. A few hand-picked lines cover
// the extremes: equal endpoints, equal deltas, negative steps, a line cut
// short by a new load and requests with no line loaded. Random lines follow,
// mostly short with a few long ones, with random gaps on the input and
// random stalls on the output. A scoreboard walks each line itself and
// checks every pixel word in order.
// ============================================================================
module line_rasterizer_tb;
    import lr_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int TARGET_ITEMS = 1900;
    localparam int MAX_WAIT     = 6;

    class pixel_scoreboard;
        t_pixel                     expected_q[$];
        int                         errors;
        int                         pixels_checked;
        int                         lines_loaded;
        int                         idle_requests;
        bit                         active;
        t_coord                     cur_x;
        t_coord                     cur_y;
        logic signed [ERR_BITS-1:0] err;
        t_coord                     delta_x;
        t_coord                     delta_y;
        bit                         x_neg;
        bit                         y_neg;
        bit                         x_major;
        t_coord                     left;
        t_color                     color;

        function new();
            errors         = 0;
            pixels_checked = 0;
            lines_loaded   = 0;
            idle_requests  = 0;
            active         = 0;
            cur_x          = '0;
            cur_y          = '0;
            err            = '0;
            delta_x        = '0;
            delta_y        = '0;
            x_neg          = 0;
            y_neg          = 0;
            x_major        = 0;
            left           = '0;
            color          = '0;
        endfunction

        function t_coord step_coord(t_coord c, bit neg);
            return neg ? t_coord'(c - 1'b1) : t_coord'(c + 1'b1);
        endfunction

        function void note_request(t_req req, logic [S_DATA_BITS-1:0] data);
            t_coord sx;
            t_coord sy;
            t_coord ex;
            t_coord ey;
            t_pixel px;
            sx = data[0 +: COORD_BITS];
            sy = data[COORD_BITS +: COORD_BITS];
            ex = data[2*COORD_BITS +: COORD_BITS];
            ey = data[3*COORD_BITS +: COORD_BITS];
            if (req == REQ_LOAD) begin
                x_neg   = ex < sx;
                y_neg   = ey < sy;
                delta_x = x_neg ? t_coord'(sx - ex) : t_coord'(ex - sx);
                delta_y = y_neg ? t_coord'(sy - ey) : t_coord'(ey - sy);
                x_major = delta_x > delta_y;
                left    = x_major ? delta_x : delta_y;
                err     = $signed({2'b00, t_coord'(left >> 1)});
                cur_x   = sx;
                cur_y   = sy;
                color   = data[4*COORD_BITS +: COLOR_BITS];
                active  = 1;
                lines_loaded++;
                return;
            end
            if (!active) begin
                idle_requests++;
                return;
            end
            px.x     = cur_x;
            px.y     = cur_y;
            px.color = color;
            px.last  = (left == 0);
            expected_q.push_back(px);
            if (left == 0) begin
                active = 0;
                return;
            end
            if (x_major) begin
                if (err <= 0) begin
                    err   = err + $signed({2'b00, delta_x});
                    cur_y = step_coord(cur_y, y_neg);
                end
                err   = err - $signed({2'b00, delta_y});
                cur_x = step_coord(cur_x, x_neg);
            end else begin
                if (err <= 0) begin
                    err   = err + $signed({2'b00, delta_y});
                    cur_x = step_coord(cur_x, x_neg);
                end
                err   = err - $signed({2'b00, delta_x});
                cur_y = step_coord(cur_y, y_neg);
            end
            left = left - 1'b1;
        endfunction

        function void compare_field(string name, int exp_val, int act_val);
            if (exp_val != act_val) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, name, exp_val, act_val);
                errors++;
            end
        endfunction

        function void check_pixel(logic [M_DATA_BITS-1:0] data, logic last);
            t_pixel px;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected pixel word, expected none, actual x=%0d y=%0d",
                         $time, data[0 +: COORD_BITS], data[COORD_BITS +: COORD_BITS]);
                errors++;
                return;
            end
            px = expected_q.pop_front();
            compare_field("pixel_x", px.x, data[0 +: COORD_BITS]);
            compare_field("pixel_y", px.y, data[COORD_BITS +: COORD_BITS]);
            compare_field("pixel_color", px.color, data[2*COORD_BITS +: COLOR_BITS]);
            compare_field("last_pixel", px.last, last);
            pixels_checked++;
        endfunction
    endclass

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_valid = 1'b0;
    logic [S_DATA_BITS-1:0] s_data = '0;
    logic [0:0]             s_user = 1'b0;
    logic                   m_ready = 1'b0;
    logic                   s_axis_tready;
    logic                   m_axis_tvalid;
    logic [M_DATA_BITS-1:0] m_axis_tdata;
    logic                   m_axis_tlast;

    pixel_scoreboard sb = new();
    int              items_sent = 0;
    int              cycle_count = 0;
    int              tx_max_gap = MAX_WAIT;
    int              rx_max_stall = MAX_WAIT;

    line_rasterizer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_axis_tready),
        // start_x, start_y, end_x, end_y, line_color, zero fill
        .s_axis_tdata  (s_data),
        // req_type
        .s_axis_tuser  (s_user),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_ready),
        // pixel_x, pixel_y, pixel_color, zero fill
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d pixels outstanding", $time,
                     sb.expected_q.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_ready)
                sb.check_pixel(m_axis_tdata, m_axis_tlast);
            if (s_valid && s_axis_tready)
                sb.note_request(t_req'(s_user), s_data);
        end
    end

    initial begin
        int stall;
        forever begin
            stall = (rx_max_stall == 0) ? 0 : $urandom_range(rx_max_stall, 0);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_ready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    task automatic send_word(t_req req, t_coord sx, t_coord sy, t_coord ex, t_coord ey,
                             t_color c);
        int gap;
        gap = (tx_max_gap == 0) ? 0 : $urandom_range(tx_max_gap, 0);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_user  <= req;
        s_data  <= {{(S_DATA_BITS - 4*COORD_BITS - COLOR_BITS){1'b0}}, c, ey, ex, sy, sx};
        do @(posedge i_clk); while (!s_axis_tready);
        items_sent++;
    endtask

    task automatic load_line(int sx, int sy, int ex, int ey, int c);
        send_word(REQ_LOAD, t_coord'(sx), t_coord'(sy), t_coord'(ex), t_coord'(ey),
                  t_color'(c));
    endtask

    // Pixel requests carry random payload, which the block must ignore.
    task automatic request_pixels(int n);
        repeat (n)
            send_word(REQ_PIXEL, t_coord'($urandom), t_coord'($urandom),
                      t_coord'($urandom), t_coord'($urandom), t_color'($urandom));
    endtask

    // The first edge lets the scoreboard note the word accepted just before.
    task automatic wait_drained();
        @(posedge i_clk);
        while (sb.expected_q.size() != 0) @(posedge i_clk);
    endtask

    function automatic int near_coord(int c);
        int v;
        v = c + $urandom_range(24, 0) - 12;
        return (v < 0) ? 0 : (v > 511) ? 511 : v;
    endfunction

    function automatic int pick_color();
        int r;
        r = $urandom_range(9, 0);
        return (r == 0) ? 0 : (r == 1) ? 16'hFFFF : $urandom_range(16'hFFFF, 0);
    endfunction

    initial begin
        int  sx, sy, ex, ey, dx, dy, npix, nreq, r;
        bit  drained_once;
        bit  span_done;
        drained_once = 0;
        span_done    = 0;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Request with nothing loaded, then a single point run past its end.
        request_pixels(1);
        load_line(5, 5, 5, 5, 0);
        request_pixels(2);
        // Equal deltas walk along y.
        load_line(0, 0, 3, 3, 16'hFFFF);
        request_pixels(4);
        load_line(511, 0, 508, 2, 16'h1234);
        request_pixels(4);
        load_line(0, 511, 2, 507, 16'hA5A5);
        request_pixels(5);
        // A new load replaces a line in progress.
        load_line(10, 10, 20, 12, 16'h00FF);
        request_pixels(2);
        load_line(511, 511, 509, 510, 16'hFF00);
        request_pixels(3);

        while (items_sent < TARGET_ITEMS) begin
            if ($urandom_range(7, 0) == 0) begin
                tx_max_gap   = 0;
                rx_max_stall = 0;
            end else begin
                tx_max_gap   = MAX_WAIT;
                rx_max_stall = MAX_WAIT;
            end
            r = $urandom_range(99, 0);
            if (!span_done && items_sent > 300) begin
                sx = 0; sy = 511; ex = 511; ey = 0;
                span_done = 1;
            end else if (r < 4) begin
                sx = $urandom_range(511, 0); sy = $urandom_range(511, 0);
                ex = $urandom_range(511, 0); ey = $urandom_range(511, 0);
            end else if (r < 6) begin
                sx = $urandom_range(1, 0) * 511; sy = $urandom_range(1, 0) * 511;
                ex = $urandom_range(1, 0) * 511; ey = $urandom_range(1, 0) * 511;
            end else begin
                sx = $urandom_range(511, 0); sy = $urandom_range(511, 0);
                ex = near_coord(sx); ey = near_coord(sy);
            end
            dx   = (ex > sx) ? ex - sx : sx - ex;
            dy   = (ey > sy) ? ey - sy : sy - ey;
            npix = ((dx > dy) ? dx : dy) + 1;
            if ($urandom_range(19, 0) == 0)
                request_pixels(1);
            load_line(sx, sy, ex, ey, pick_color());
            r = $urandom_range(99, 0);
            if (r < 15)
                nreq = $urandom_range(npix, 0);
            else if (r < 30)
                nreq = npix + $urandom_range(3, 1);
            else
                nreq = npix;
            request_pixels(nreq);
            if (!drained_once && items_sent > TARGET_ITEMS / 2) begin
                s_valid <= 1'b0;
                wait_drained();
                drained_once = 1;
            end
        end
        s_valid <= 1'b0;

        wait_drained();
        repeat (10) @(posedge i_clk);

        $display("Sent %0d words: %0d line loads, %0d requests with no line loaded.",
                 items_sent, sb.lines_loaded, sb.idle_requests);
        $display("Checked %0d pixel words; %0d still expected.", sb.pixels_checked,
                 sb.expected_q.size());
        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
